### src/ddo_pkg.sv
// Package for the differential drive odometry block.
// Holds payload structs, opcodes, register indexes and fixed-point constants.
// No dependencies.
package ddo_pkg;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_LOAD   = 2'd1,
    OP_ZERO   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam logic [2:0] REG_MPT     = 3'd0;
  localparam logic [2:0] REG_RPM     = 3'd1;
  localparam logic [2:0] REG_MIN_US  = 3'd2;
  localparam logic [2:0] REG_START_X = 3'd3;
  localparam logic [2:0] REG_START_Y = 3'd4;
  localparam logic [2:0] REG_START_H = 3'd5;

  localparam logic signed [36:0] PI_Q24      = 37'sd52707179;
  localparam logic signed [36:0] TWO_PI_Q24  = 37'sd105414357;
  localparam logic signed [36:0] HALF_PI_Q24 = 37'sd26353589;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] left_ticks;
    logic signed [31:0] right_ticks;
    logic [19:0]        elapsed_us;
    logic [7:0]         pose_x_byte;
    logic [7:0]         pose_y_byte;
    logic [7:0]         pose_heading_byte;
  } in_t;

  typedef struct packed {
    logic               updated;
    logic signed [31:0] x_pos;
    logic signed [31:0] y_pos;
    logic signed [31:0] heading;
    logic signed [31:0] forward_speed;
    logic signed [31:0] turn_rate;
    logic signed [31:0] left_speed;
    logic signed [31:0] right_speed;
  } out_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DIFF, S_MUL_L, S_MUL_R, S_ROT, S_ANG, S_MOD, S_FOLD, S_CORDIC,
    S_PX, S_PY, S_SPD_MUL, S_SPD_DIV, S_SPD_ST, S_LOAD, S_OUT
  } state_e;

  // Control from the sequencer to the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  return 34'h03243F6A8 ;
      5'd1:  return 34'h01DAC6705;
      5'd2:  return 34'h00FADBAFC;
      5'd3:  return 34'h007F56EA6;
      5'd4:  return 34'h003FEAB76;
      5'd5:  return 34'h001FFD55B;
      5'd6:  return 34'h000FFFAAA;
      5'd7:  return 34'h0007FFF55;
      5'd8:  return 34'h0003FFFEA;
      5'd9:  return 34'h0001FFFFD;
      5'd10: return 34'h0000FFFFF;
      5'd11: return 34'h00007FFFF;
      5'd12: return 34'h00003FFFF;
      5'd13: return 34'h00001FFFF;
      5'd14: return 34'h00000FFFF;
      5'd15: return 34'h000007FFF;
      5'd16: return 34'h000003FFF;
      5'd17: return 34'h000001FFF;
      5'd18: return 34'h000000FFF;
      5'd19: return 34'h0000007FF;
      5'd20: return 34'h0000003FF;
      5'd21: return 34'h0000001FF;
      5'd22: return 34'h0000000FF;
      5'd23: return 34'h00000007F;
      5'd24: return 34'h00000003F;
      5'd25: return 34'h00000001F;
      5'd26: return 34'h00000000F;
      5'd27: return 34'h000000008;
      5'd28: return 34'h000000004;
      5'd29: return 34'h000000002;
      5'd30: return 34'h000000001;
      default: return 34'h0;
    endcase
  endfunction

endpackage

### src/ddo_div.sv
// Restoring divider for the odometry speeds, one quotient bit per cycle.
// Signed dividend, unsigned divisor, quotient truncated toward zero.
// Depends on ddo_pkg.
module ddo_div
  import ddo_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  div_ctl_t           ctl_i,
  input  logic signed [63:0] dividend_i,
  input  logic [27:0]        divisor_i,
  output div_sts_t           sts_o,
  output logic signed [31:0] quot_o
);

  logic [62:0] rem_q, rem_d;
  logic [62:0] quo_q, quo_d;
  logic [27:0] dvs_q, dvs_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [63:0] mag;
  logic [63:0] trial;
  logic signed [64:0] sq;

  always_comb begin
    mag    = dividend_i[63] ? 64'(-dividend_i) : 64'(dividend_i);
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[62]} - {36'd0, dvs_q};
    if (ctl_i.start) begin
      rem_d  = '0;
      quo_d  = mag[62:0];
      dvs_d  = divisor_i;
      neg_d  = dividend_i[63];
      cnt_d  = 6'd63;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[63]) begin
        rem_d = trial[62:0];
        quo_d = {quo_q[61:0], 1'b1};
      end else begin
        rem_d = {rem_q[61:0], quo_q[62]};
        quo_d = {quo_q[61:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign sq          = neg_q ? -$signed({2'b0, quo_q}) : $signed({2'b0, quo_q});
  assign quot_o      = sat32(66'(sq));
  assign sts_o.busy  = busy_q;
  assign sts_o.done  = done_q;

endmodule

### src/differential_drive_odometry.sv
// Top level of the differential drive odometry block.
// Holds the configuration registers, pose state, sequencer, one shared
// multiplier, the CORDIC rotator and the divider; depends on ddo_pkg, ddo_div.
//
// Usage: an item is a transaction on the in channel (in_valid_i, in_ready_o,
// in_data_i). Every item gives exactly one result transaction on the out
// channel (out_valid_o, out_ready_i, out_data_o), carrying the pose and the
// stored speeds. Configuration is written through cfg_valid_i, cfg_ready_o,
// cfg_index_i and cfg_data_i; writing a start register also loads that
// pose component. Writes are taken only while the block is idle.
// An update item above the time threshold raises out_valid_o after the
// CORDIC iterations, a six-step angle reduction and four divisions in the
// shared divider. A load item passes through the load state; zero, unknown
// and below-threshold update items go straight to the result state.
// The block takes one item at a time; in_ready_o is low from acceptance until
// the result has been taken. If the receiver stalls, the result is held
// stable in the output register. After reset the pose and speeds are zero,
// the tick references are zero and the update threshold is 20000 us.
module differential_drive_odometry
  import ddo_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  state_e state_q, state_d;

  logic [31:0] mpt_q;
  logic [23:0] rpm_q;
  logic [19:0] min_us_q;
  logic signed [31:0] px_q, py_q, ph_q;
  logic signed [31:0] px_d, py_d, ph_d;
  logic signed [31:0] lastl_q, lastr_q, lastl_d, lastr_d;
  logic signed [31:0] spd_q [4];
  logic signed [31:0] spd_d [4];
  in_t  item_q, item_d;
  logic upd_q, upd_d;
  out_t res_q, res_d;
  logic out_valid_q, out_valid_d;

  // Working registers.
  logic signed [31:0] dtl_q, dtl_d, dtr_q, dtr_d;
  logic signed [31:0] dl_q, dl_d, dr_q, dr_d, drot_q, drot_d;
  logic signed [32:0] dfwd_q, dfwd_d;
  logic signed [36:0] ang_q, ang_d;
  logic               neg_q, neg_d;
  logic signed [33:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic [4:0]         it_q, it_d;
  logic [1:0]         sel_q, sel_d;
  logic signed [63:0] num_q, num_d;

  // Shared multiplier.
  logic signed [33:0] ma, mb;
  logic signed [67:0] mp;
  assign mp = ma * mb;

  div_ctl_t           dctl;
  div_sts_t           dsts;
  logic signed [31:0] dquot;
  logic [27:0]        dvs;

  ddo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (dctl),
    .dividend_i (num_q),
    .divisor_i  (dvs),
    .sts_o      (dsts),
    .quot_o     (dquot)
  );

  assign dvs = (sel_q == 2'd1) ? {item_q.elapsed_us, 8'd0} : {8'd0, item_q.elapsed_us};

  logic cfg_fire, in_fire;
  assign cfg_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // Exact floor of m / 255 for m below 65025.
  function automatic logic [31:0] div255(input logic [15:0] m);
    logic [16:0] t;
    t = 17'(m) + 17'd1 + 17'(m[15:8]);
    return 32'(t[16:8]);
  endfunction

  logic signed [36:0] r0;
  logic signed [33:0] xs, ys;
  logic signed [65:0] wide;

  always_comb begin
    state_d = state_q;
    px_d = px_q; py_d = py_q; ph_d = ph_q;
    lastl_d = lastl_q; lastr_d = lastr_q;
    spd_d = spd_q;
    item_d = item_q; upd_d = upd_q;
    res_d = res_q; out_valid_d = out_valid_q;
    dtl_d = dtl_q; dtr_d = dtr_q; dl_d = dl_q; dr_d = dr_q; drot_d = drot_q;
    dfwd_d = dfwd_q; ang_d = ang_q; neg_d = neg_q;
    cx_d = cx_q; cy_d = cy_q; cz_d = cz_q; it_d = it_q; sel_d = sel_q;
    num_d = num_q;
    dctl.start = 1'b0;
    ma = '0; mb = '0;
    r0 = '0; wide = '0;
    xs = cx_q >>> it_q;
    ys = cy_q >>> it_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cfg_fire) begin
      case (cfg_index_i)
        REG_START_X: px_d = cfg_data_i;
        REG_START_Y: py_d = cfg_data_i;
        REG_START_H: ph_d = cfg_data_i;
        default: ;
      endcase
    end
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          item_d = in_data_i;
          upd_d  = 1'b0;
          case (op_e'(in_data_i.operation))
            OP_UPDATE: state_d = (in_data_i.elapsed_us > min_us_q) ? S_DIFF : S_OUT;
            OP_LOAD:   state_d = S_LOAD;
            OP_ZERO: begin
              lastl_d = '0; lastr_d = '0; state_d = S_OUT;
            end
            default:   state_d = S_OUT;
          endcase
        end
      end
      S_DIFF: begin
        dtl_d = item_q.left_ticks - lastl_q;
        dtr_d = item_q.right_ticks - lastr_q;
        state_d = S_MUL_L;
      end
      S_MUL_L: begin
        ma = 34'(dtl_q); mb = $signed({2'b0, mpt_q});
        dl_d = sat32(66'(mp >>> 16));
        state_d = S_MUL_R;
      end
      S_MUL_R: begin
        ma = 34'(dtr_q); mb = $signed({2'b0, mpt_q});
        dr_d = sat32(66'(mp >>> 16));
        state_d = S_ROT;
      end
      S_ROT: begin
        dfwd_d = (33'(dl_q) + 33'(dr_q)) >>> 1;
        ma = 34'(dr_q) - 34'(dl_q); mb = $signed({10'b0, rpm_q});
        drot_d = sat32(66'(mp >>> 8));
        state_d = S_ANG;
      end
      S_ANG: begin
        r0 = 37'(ph_q) + 37'(drot_q >>> 1);
        neg_d = r0[36];
        ang_d = r0[36] ? -r0 : r0;
        it_d = 5'd5;
        state_d = S_MOD;
      end
      S_MOD: begin
        // The magnitude is reduced modulo two pi by shifted subtraction.
        if (ang_q >= (TWO_PI_Q24 <<< it_q)) begin
          ang_d = ang_q - (TWO_PI_Q24 <<< it_q);
        end
        it_d = it_q - 5'd1;
        if (it_q == 5'd0) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        r0 = ang_q;
        if (r0 > PI_Q24) begin
          r0 = neg_q ? TWO_PI_Q24 - r0 : r0 - TWO_PI_Q24;
        end else if (neg_q) begin
          r0 = -r0;
        end
        neg_d = 1'b0;
        if (r0 > HALF_PI_Q24) begin
          r0 = r0 - PI_Q24; neg_d = 1'b1;
        end else if (r0 < -HALF_PI_Q24) begin
          r0 = r0 + PI_Q24; neg_d = 1'b1;
        end
        cz_d = 34'(r0 <<< 6);
        cx_d = GAIN_Q30;
        cy_d = '0;
        it_d = '0;
        state_d = S_CORDIC;
      end
      S_CORDIC: begin
        if (!cz_q[33]) begin
          cx_d = cx_q - ys; cy_d = cy_q + xs; cz_d = cz_q - atan_q30(it_q);
        end else begin
          cx_d = cx_q + ys; cy_d = cy_q - xs; cz_d = cz_q + atan_q30(it_q);
        end
        it_d = it_q + 5'd1;
        if (32'(it_q) == STEPS - 1) begin
          if (neg_q) begin
            cx_d = -cx_d; cy_d = -cy_d;
          end
          state_d = S_PX;
        end
      end
      S_PX: begin
        ma = 34'(dfwd_q); mb = cx_q;
        wide = 66'(px_q) + 66'(mp >>> 30);
        px_d = sat32(wide);
        state_d = S_PY;
      end
      S_PY: begin
        ma = 34'(dfwd_q); mb = cy_q;
        wide = 66'(py_q) + 66'(mp >>> 30);
        py_d = sat32(wide);
        ph_d = sat32(66'(ph_q) + 66'(drot_q));
        sel_d = 2'd0;
        state_d = S_SPD_MUL;
      end
      S_SPD_MUL: begin
        case (sel_q)
          2'd0: ma = 34'(dfwd_q);
          2'd1: ma = 34'(drot_q);
          2'd2: ma = 34'(dl_q);
          default: ma = 34'(dr_q);
        endcase
        mb = 34'sd1000000;
        num_d = mp[63:0];
        state_d = S_SPD_DIV;
      end
      S_SPD_DIV: begin
        dctl.start = 1'b1;
        state_d = S_SPD_ST;
      end
      S_SPD_ST: begin
        if (dsts.done) begin
          spd_d[sel_q] = dquot;
          sel_d = sel_q + 2'd1;
          if (sel_q == 2'd3) begin
            lastl_d = item_q.left_ticks;
            lastr_d = item_q.right_ticks;
            upd_d = 1'b1;
            state_d = S_OUT;
          end else begin
            state_d = S_SPD_MUL;
          end
        end
      end
      S_LOAD: begin
        // Each scale is split into a multiple of 255 and a small remainder.
        px_d = 32'(item_q.pose_x_byte) * 32'd771 +
               div255(16'(item_q.pose_x_byte) * 16'd3);
        py_d = 32'(item_q.pose_y_byte) * 32'd514 +
               div255(16'(item_q.pose_y_byte) * 16'd2);
        ph_d = 32'(item_q.pose_heading_byte) * 32'd413389 +
               div255(16'(item_q.pose_heading_byte) * 16'd162) - 32'(PI_Q24);
        state_d = S_OUT;
      end
      S_OUT: begin
        res_d.updated       = upd_q;
        res_d.x_pos         = px_q;
        res_d.y_pos         = py_q;
        res_d.heading       = ph_q;
        res_d.forward_speed = spd_q[0];
        res_d.turn_rate     = spd_q[1];
        res_d.left_speed    = spd_q[2];
        res_d.right_speed   = spd_q[3];
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      mpt_q       <= '0;
      rpm_q       <= '0;
      min_us_q    <= 20'd20000;
      px_q        <= '0;
      py_q        <= '0;
      ph_q        <= '0;
      lastl_q     <= '0;
      lastr_q     <= '0;
      for (int k = 0; k < 4; k++) spd_q[k] <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_fire) begin
        case (cfg_index_i)
          REG_MPT:    mpt_q    <= cfg_data_i;
          REG_RPM:    rpm_q    <= cfg_data_i[23:0];
          REG_MIN_US: min_us_q <= cfg_data_i[19:0];
          default: ;
        endcase
      end
      px_q    <= px_d;
      py_q    <= py_d;
      ph_q    <= ph_d;
      lastl_q <= lastl_d;
      lastr_q <= lastr_d;
      spd_q   <= spd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d; upd_q <= upd_d; res_q <= res_d;
    dtl_q <= dtl_d; dtr_q <= dtr_d; dl_q <= dl_d; dr_q <= dr_d;
    drot_q <= drot_d; dfwd_q <= dfwd_d; ang_q <= ang_d; neg_q <= neg_d;
    cx_q <= cx_d; cy_q <= cy_d; cz_q <= cz_d; it_q <= it_d; sel_q <= sel_d;
    num_q <= num_d;
  end

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("ready while busy");
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT)) else $error("stray result");
  a_div_only_in_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dsts.done |-> (state_q == S_SPD_ST)) else $error("divider out of step");
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dctl.start |-> !dsts.busy) else $error("divider started while busy");

endmodule
